>>> design/hsvrgb_pkg.sv
// Shared constants and types for the HSV to RGB converter.
// No dependencies; used by hsvrgb_chan and hsv_to_rgb_converter.
package hsvrgb_pkg;

   localparam int HUE_W   = 16;   // hue port, 1/16 degree, signed
   localparam int SV_W    = 18;   // saturation / value ports, Q1.16 signed
   localparam int UNIT_W  = 17;   // clamped 0..65536
   localparam int BYTE_W  = 8;
   localparam int WRAP_W  = 17;   // biased hue, 0..67327
   localparam int QUO_W   = 7;    // biased hue / 960, 0..70
   localparam int FRAC_W  = 10;   // position in sector, 0..959
   localparam int K_W     = 11;   // ramp weight, 0..960
   localparam int C32_W   = 33;   // s*v, up to 2^32
   localparam int CH_W    = 42;   // channel at scale 960*2^32
   localparam int ACC_W   = 50;   // 255*channel plus rounding half
   localparam int T_W     = 18;   // rounded sum shifted down by 2^32

   localparam logic [UNIT_W-1:0] Q_ONE       = 17'd65536;
   localparam logic [WRAP_W-1:0] HUE_BIAS    = 17'd34560;  // 6 * 5760
   localparam logic [K_W-1:0]    HUE_SECTOR  = 11'd960;
   localparam logic [12:0]       RECIP15     = 13'd4370;   // ~ 2^16 / 15, exact here
   localparam logic [7:0]        RECIP6      = 8'd171;     // ~ 2^10 / 6, exact here
   localparam logic [CH_W-1:0]   CH_MAX      = 42'h3C000000000; // 960 << 32
   localparam logic [ACC_W-1:0]  ROUND_HALF  = 50'h1E000000000; // 480 << 32

   // 60 degree hue sectors
   typedef enum logic [2:0] {
      SEC_RED_YEL = 3'd0,
      SEC_YEL_GRN = 3'd1,
      SEC_GRN_CYN = 3'd2,
      SEC_CYN_BLU = 3'd3,
      SEC_BLU_MAG = 3'd4,
      SEC_MAG_RED = 3'd5
   } sector_type;

endpackage

>>> design/hsvrgb_chan.sv
// One output channel: clamp, scale by 255 with round-half-up, divide by 960*2^32.
// Two register stages. Uses hsvrgb_pkg.
module hsvrgb_chan (
   input  logic                           clock,
   input  logic [hsvrgb_pkg::CH_W-1:0]    chan,
   output logic [hsvrgb_pkg::BYTE_W-1:0]  chan_byte
);

   logic [hsvrgb_pkg::CH_W-1:0]   clamped;
   logic [hsvrgb_pkg::ACC_W-1:0]  acc;
   logic [hsvrgb_pkg::T_W-1:0]    t_in, t_ff;
   logic [24:0]                   prod;
   logic [hsvrgb_pkg::BYTE_W-1:0] byte_in, byte_ff;

   // 255*N + 480*2^32, then drop the 2^32 scale
   always_comb begin
      clamped = (chan > hsvrgb_pkg::CH_MAX) ? hsvrgb_pkg::CH_MAX : chan;
      acc     = {clamped, 8'd0} - {8'd0, clamped} + hsvrgb_pkg::ROUND_HALF;
      t_in    = acc[hsvrgb_pkg::ACC_W-1:32];
   end

   // floor(t / 960) = floor(floor(t / 64) / 15)
   always_comb begin
      prod    = {1'b0, t_ff[hsvrgb_pkg::T_W-1:6]} * {12'd0, hsvrgb_pkg::RECIP15};
      byte_in = prod[23:16];
   end

   always_ff @(posedge clock) begin
      t_ff    <= t_in;
      byte_ff <= byte_in;
   end

   assign chan_byte = byte_ff;

endmodule

>>> design/hsv_to_rgb_converter.sv
// HSV to 8-bit RGB converter, top level: hue wrap, chroma, sector mapping.
// Uses hsvrgb_pkg and three hsvrgb_chan instances.
//
// One color per transfer, one result per transfer, one transfer per clock.
// A color taken when start is high and busy is low comes out on the rsp_
// ports with rsp_valid high once it has passed through the six stages:
// hue wrap and clamping, chroma multiply and sector decode, ramp multiply,
// channel select and offset add, then two stages per channel for the x255
// scaling with round-half-up and the divide by 960. The pipeline never stalls
// since results cannot be held off, so busy is low except during reset.
// Hue is in 1/16 degree and wraps modulo 360 degrees, negatives included;
// saturation and value are Q1.16 and clamped to 0..1.
module hsv_to_rgb_converter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [hsvrgb_pkg::HUE_W-1:0]   req_hue,
   input  logic signed [hsvrgb_pkg::SV_W-1:0]    req_saturation,
   input  logic signed [hsvrgb_pkg::SV_W-1:0]    req_brightness,
   output logic                                  rsp_valid,
   output logic [hsvrgb_pkg::BYTE_W-1:0]         rsp_red,
   output logic [hsvrgb_pkg::BYTE_W-1:0]         rsp_green,
   output logic [hsvrgb_pkg::BYTE_W-1:0]         rsp_blue
);

   localparam int DEPTH = 6;

   // valid bits travel alongside the data
   logic [DEPTH-1:0] valid_in, valid_ff;

   // ---- stage 1: clamp s, v; bias hue positive; coarse quotient by 960
   logic [hsvrgb_pkg::UNIT_W-1:0] s1_sat_in, s1_sat_ff, s1_val_in, s1_val_ff;
   logic [hsvrgb_pkg::WRAP_W-1:0] s1_hue_in, s1_hue_ff;
   logic [hsvrgb_pkg::QUO_W-1:0]  s1_quo_in, s1_quo_ff;
   logic [17:0]                   hue_sum;
   logic [23:0]                   quo_prod;

   // ---- stage 2: sector, ramp weight, chroma
   logic [hsvrgb_pkg::K_W-1:0]     s2_k_in, s2_k_ff;
   hsvrgb_pkg::sector_type         s2_sec_in, s2_sec_ff;
   logic [hsvrgb_pkg::C32_W-1:0]   s2_c32_in, s2_c32_ff;
   logic [hsvrgb_pkg::UNIT_W-1:0]  s2_val_ff;
   logic [hsvrgb_pkg::WRAP_W-1:0]  quo_x960;
   logic [hsvrgb_pkg::FRAC_W-1:0]  frac;
   logic [14:0]                    six_prod;
   logic [3:0]                     quo6;
   logic [hsvrgb_pkg::QUO_W-1:0]   sec_raw;
   logic [33:0]                    sv_prod;

   // ---- stage 3: full chroma, ramp component, offset
   logic [hsvrgb_pkg::CH_W-1:0]    s3_cc_in, s3_cc_ff, s3_xx_in, s3_xx_ff, s3_mm_in, s3_mm_ff;
   hsvrgb_pkg::sector_type         s3_sec_ff;
   logic [43:0]                    xk_prod;
   logic [hsvrgb_pkg::C32_W-1:0]   offs;

   // ---- stage 4: per-channel select plus offset
   logic [hsvrgb_pkg::CH_W-1:0]    s4_r_in, s4_r_ff, s4_g_in, s4_g_ff, s4_b_in, s4_b_ff;
   logic [hsvrgb_pkg::CH_W-1:0]    sel_r, sel_g, sel_b;

   assign busy = reset;

   always_comb begin
      valid_in = {valid_ff[DEPTH-2:0], start & ~busy};
   end

   // stage 1
   always_comb begin
      // 6*360 degrees of bias makes every hue non-negative
      hue_sum   = {{2{req_hue[hsvrgb_pkg::HUE_W-1]}}, req_hue} + {1'b0, hsvrgb_pkg::HUE_BIAS};
      s1_hue_in = hue_sum[hsvrgb_pkg::WRAP_W-1:0];
      // /960 = /64 then /15 by reciprocal
      quo_prod  = s1_hue_in[hsvrgb_pkg::WRAP_W-1:6] * {11'd0, hsvrgb_pkg::RECIP15};
      s1_quo_in = quo_prod[22:16];

      if (req_saturation < 0) begin
         s1_sat_in = '0;
      end else if (req_saturation > $signed({1'b0, hsvrgb_pkg::Q_ONE})) begin
         s1_sat_in = hsvrgb_pkg::Q_ONE;
      end else begin
         s1_sat_in = req_saturation[hsvrgb_pkg::UNIT_W-1:0];
      end

      if (req_brightness < 0) begin
         s1_val_in = '0;
      end else if (req_brightness > $signed({1'b0, hsvrgb_pkg::Q_ONE})) begin
         s1_val_in = hsvrgb_pkg::Q_ONE;
      end else begin
         s1_val_in = req_brightness[hsvrgb_pkg::UNIT_W-1:0];
      end
   end

   // stage 2
   always_comb begin
      quo_x960  = {s1_quo_ff, 10'd0} - {4'd0, s1_quo_ff, 6'd0};
      frac      = s1_hue_ff[hsvrgb_pkg::FRAC_W-1:0] - quo_x960[hsvrgb_pkg::FRAC_W-1:0];
      // quotient mod 6 gives the sector
      six_prod  = s1_quo_ff * {7'd0, hsvrgb_pkg::RECIP6};
      quo6      = six_prod[13:10];
      sec_raw   = s1_quo_ff - ({1'b0, quo6, 2'd0} + {2'd0, quo6, 1'b0});
      s2_sec_in = hsvrgb_pkg::sector_type'(sec_raw[2:0]);
      // falling ramp in odd sectors
      s2_k_in   = sec_raw[0] ? (hsvrgb_pkg::HUE_SECTOR - {1'b0, frac}) : {1'b0, frac};
      sv_prod   = s1_sat_ff * s1_val_ff;
      s2_c32_in = sv_prod[hsvrgb_pkg::C32_W-1:0];
   end

   // stage 3
   always_comb begin
      xk_prod  = s2_c32_ff * s2_k_ff;
      s3_xx_in = xk_prod[hsvrgb_pkg::CH_W-1:0];
      s3_cc_in = {s2_c32_ff, 9'd0} + {s2_c32_ff, 9'd0} - {3'd0, s2_c32_ff, 6'd0};
      offs     = {s2_val_ff[15:0] & 16'd0, 17'd0} + {s2_val_ff, 16'd0} - s2_c32_ff;
      s3_mm_in = {offs, 9'd0} + {offs, 9'd0} - {3'd0, offs, 6'd0};
   end

   // stage 4
   always_comb begin
      unique case (s3_sec_ff)
         hsvrgb_pkg::SEC_RED_YEL: begin
            sel_r = s3_cc_ff; sel_g = s3_xx_ff; sel_b = '0;
         end
         hsvrgb_pkg::SEC_YEL_GRN: begin
            sel_r = s3_xx_ff; sel_g = s3_cc_ff; sel_b = '0;
         end
         hsvrgb_pkg::SEC_GRN_CYN: begin
            sel_r = '0; sel_g = s3_cc_ff; sel_b = s3_xx_ff;
         end
         hsvrgb_pkg::SEC_CYN_BLU: begin
            sel_r = '0; sel_g = s3_xx_ff; sel_b = s3_cc_ff;
         end
         hsvrgb_pkg::SEC_BLU_MAG: begin
            sel_r = s3_xx_ff; sel_g = '0; sel_b = s3_cc_ff;
         end
         default: begin
            sel_r = s3_cc_ff; sel_g = '0; sel_b = s3_xx_ff;
         end
      endcase
      s4_r_in = sel_r + s3_mm_ff;
      s4_g_in = sel_g + s3_mm_ff;
      s4_b_in = sel_b + s3_mm_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sat_ff <= s1_sat_in;
      s1_val_ff <= s1_val_in;
      s1_hue_ff <= s1_hue_in;
      s1_quo_ff <= s1_quo_in;
      s2_k_ff   <= s2_k_in;
      s2_sec_ff <= s2_sec_in;
      s2_c32_ff <= s2_c32_in;
      s2_val_ff <= s1_val_ff;
      s3_cc_ff  <= s3_cc_in;
      s3_xx_ff  <= s3_xx_in;
      s3_mm_ff  <= s3_mm_in;
      s3_sec_ff <= s2_sec_ff;
      s4_r_ff   <= s4_r_in;
      s4_g_ff   <= s4_g_in;
      s4_b_ff   <= s4_b_in;
   end

   // stages 5 and 6 live in the channel quantizers
   hsvrgb_chan u_chan_red (
      .clock     (clock),
      .chan      (s4_r_ff),
      .chan_byte (rsp_red)
   );

   hsvrgb_chan u_chan_green (
      .clock     (clock),
      .chan      (s4_g_ff),
      .chan_byte (rsp_green)
   );

   hsvrgb_chan u_chan_blue (
      .clock     (clock),
      .chan      (s4_b_ff),
      .chan_byte (rsp_blue)
   );

   assign rsp_valid = valid_ff[DEPTH-1];

endmodule

>>> test/tb_top.sv
// Self-checking bench for hsv_to_rgb_converter: directed corner colors, then
// random colors with random idle gaps, checked against a bit-exact predictor.
// Depends on hsvrgb_pkg and the converter RTL only.
module tb_top;

   // hue units per full turn (6 sectors of 60 degrees, 1/16 degree each)
   localparam int HUE_TURN = 6 * int'(hsvrgb_pkg::HUE_SECTOR);
   localparam int PIPE_LAT = 6;
   localparam int END_WAIT = 2 * PIPE_LAT;
   localparam int N_RANDOM = 1550;

   typedef struct {
      logic signed [hsvrgb_pkg::HUE_W-1:0] hue;
      logic signed [hsvrgb_pkg::SV_W-1:0]  sat;
      logic signed [hsvrgb_pkg::SV_W-1:0]  bri;
      int unsigned                         gap;    // idle cycles before this transfer
      bit                                  drain;  // hold off until the pipe is empty
   } color_item_type;

   typedef struct {
      logic [hsvrgb_pkg::BYTE_W-1:0] red;
      logic [hsvrgb_pkg::BYTE_W-1:0] green;
      logic [hsvrgb_pkg::BYTE_W-1:0] blue;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic signed [hsvrgb_pkg::HUE_W-1:0] req_hue = '0;
   logic signed [hsvrgb_pkg::SV_W-1:0]  req_saturation = '0;
   logic signed [hsvrgb_pkg::SV_W-1:0]  req_brightness = '0;
   logic busy;
   logic rsp_valid;
   logic [hsvrgb_pkg::BYTE_W-1:0] rsp_red, rsp_green, rsp_blue;

   color_item_type color_q[$];      // colors waiting to be sent
   rgb_type        rgb_expected[$]; // predicted pixels, oldest first
   color_item_type staged;
   bit             have_staged = 1'b0;
   int unsigned    idle_left = 0;
   int             fail_count = 0;

   always #6 clock = ~clock;

   hsv_to_rgb_converter DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // ------------------------------------------------------------------
   // Predictor. All channel math is exact at scale 960 * 2^32, so a
   // 64-bit unsigned holds every intermediate (max ~2^51 after x510).
   // ------------------------------------------------------------------
   function automatic int clamp_unit(input logic signed [hsvrgb_pkg::SV_W-1:0] q);
      if (q < 0) return 0;
      if (q > int'(hsvrgb_pkg::Q_ONE)) return int'(hsvrgb_pkg::Q_ONE);
      return int'(q);
   endfunction

   // round to nearest, ties up: floor((510*ch + D) / 2D)
   function automatic logic [hsvrgb_pkg::BYTE_W-1:0] channel_byte(
         input longint unsigned ch);
      longint unsigned full;
      longint unsigned scaled;
      full = longint'(hsvrgb_pkg::HUE_SECTOR) << 32;
      if (ch > full) ch = full;
      scaled = (ch * 510 + full) / (full * 2);
      return scaled[hsvrgb_pkg::BYTE_W-1:0];
   endfunction

   function automatic rgb_type hsv_pixel(input logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
                                         input logic signed [hsvrgb_pkg::SV_W-1:0]  sat,
                                         input logic signed [hsvrgb_pkg::SV_W-1:0]  bri);
      int h, s, v, f, k;
      hsvrgb_pkg::sector_type sec;
      longint unsigned chroma, c_full, ramp, offset, r, g, b;
      rgb_type px;
      // true modulo: negative hues wrap up into 0..359.9375 degrees
      h = int'(hue) % HUE_TURN;
      if (h < 0) h += HUE_TURN;
      s = clamp_unit(sat);
      v = clamp_unit(bri);
      sec = hsvrgb_pkg::sector_type'(h / int'(hsvrgb_pkg::HUE_SECTOR));
      f = h % int'(hsvrgb_pkg::HUE_SECTOR);
      // odd sectors ramp down, even ones ramp up
      k = sec[0] ? int'(hsvrgb_pkg::HUE_SECTOR) - f : f;
      chroma = longint'(s) * longint'(v);
      c_full = chroma * longint'(hsvrgb_pkg::HUE_SECTOR);
      ramp   = chroma * longint'(k);
      offset = (longint'(v) << 16) * longint'(hsvrgb_pkg::HUE_SECTOR) - c_full;
      case (sec)
         hsvrgb_pkg::SEC_RED_YEL: begin r = c_full; g = ramp;   b = 0;      end
         hsvrgb_pkg::SEC_YEL_GRN: begin r = ramp;   g = c_full; b = 0;      end
         hsvrgb_pkg::SEC_GRN_CYN: begin r = 0;      g = c_full; b = ramp;   end
         hsvrgb_pkg::SEC_CYN_BLU: begin r = 0;      g = ramp;   b = c_full; end
         hsvrgb_pkg::SEC_BLU_MAG: begin r = ramp;   g = 0;      b = c_full; end
         default:                 begin r = c_full; g = 0;      b = ramp;   end
      endcase
      px.red   = channel_byte(r + offset);
      px.green = channel_byte(g + offset);
      px.blue  = channel_byte(b + offset);
      return px;
   endfunction

   // ------------------------------------------------------------------
   // Driver. The current color is taken at an edge where start is high
   // and busy is low; the prediction is queued at that same edge. The
   // next color then waits out its idle gap and, if flagged, an empty pipe.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            rgb_expected.push_back(hsv_pixel(req_hue, req_saturation, req_brightness));
         if (!(start && busy)) begin
            if (!have_staged && color_q.size() > 0) begin
               staged = color_q.pop_front();
               have_staged = 1'b1;
               idle_left = staged.gap;
            end
            if (have_staged && idle_left == 0 &&
                !(staged.drain && rgb_expected.size() != 0)) begin
               start <= 1'b1;
               req_hue <= staged.hue;
               req_saturation <= staged.sat;
               req_brightness <= staged.bri;
               have_staged = 1'b0;
            end else begin
               if (idle_left > 0) idle_left--;
               start <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. A pixel is on the rsp_ ports for one cycle only, so each
   // strobe is one transfer, checked against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (rgb_expected.size() == 0) begin
            $error("unexpected pixel r=%0d g=%0d b=%0d", rsp_red, rsp_green, rsp_blue);
            fail_count++;
         end else begin
            rgb_type want;
            want = rgb_expected.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, actual %0d", want.red, rsp_red);
               fail_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, actual %0d", want.green, rsp_green);
               fail_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, actual %0d", want.blue, rsp_blue);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   task automatic add_color(input int hue, input int sat, input int bri,
                            input int unsigned gap, input bit drain);
      color_item_type it;
      it.hue = hue[hsvrgb_pkg::HUE_W-1:0];
      it.sat = sat[hsvrgb_pkg::SV_W-1:0];
      it.bri = bri[hsvrgb_pkg::SV_W-1:0];
      it.gap = gap;
      it.drain = drain;
      color_q.push_back(it);
   endtask

   // mostly legal 0..1 values, some clamp corners, some raw 18-bit noise
   function automatic int draw_unit();
      int pick;
      int corner[6] = '{0, 65536, -1, 65537, -131072, 131071};
      pick = $urandom_range(0, 9);
      if (pick < 5) return $urandom_range(0, 65536);
      if (pick < 7) return corner[$urandom_range(0, 5)];
      return int'($signed(18'($urandom)));
   endfunction

   initial begin
      bit burst;
      int unsigned gap;

      // directed: hue wrap corners, every sector, clamp corners, rounding tie
      add_color(0, 65536, 65536, 0, 1'b0);
      add_color(-32768, 65536, 65536, 0, 1'b0);
      add_color(32767, 65536, 65536, 3, 1'b0);
      add_color(-1, 65536, 65536, 0, 1'b0);
      add_color(-16, 40000, 50000, 1, 1'b0);   // wraps to 359 degrees
      add_color(5760, 65536, 65536, 0, 1'b0);  // 360 degrees -> 0
      add_color(5759, 65536, 65536, 0, 1'b0);
      add_color(480, 65536, 65536, 2, 1'b0);
      add_color(1440, 65536, 65536, 0, 1'b0);
      add_color(2400, 65536, 65536, 0, 1'b0);
      add_color(3360, 65536, 65536, 5, 1'b0);
      add_color(4320, 65536, 65536, 0, 1'b0);
      add_color(5280, 65536, 65536, 0, 1'b0);
      add_color(960, 30000, 60000, 0, 1'b0);   // sector edges
      add_color(959, 30000, 60000, 0, 1'b0);
      add_color(4800, 30000, 60000, 0, 1'b0);
      add_color(1000, -131072, 131071, 7, 1'b0); // sat low clamp, value high clamp
      add_color(2000, 131071, -131072, 0, 1'b0);
      add_color(3000, -1, 65537, 0, 1'b0);
      add_color(3000, 65537, -1, 0, 1'b0);
      add_color(3000, 65535, 65535, 0, 1'b0);
      add_color(0, 0, 32768, 0, 1'b1);         // grey at 127.5: tie rounds up
      add_color(-5760, 0, 0, 0, 1'b0);
      add_color(12345, 1, 1, 19, 1'b0);

      // random: each run of 40 colors is back-to-back or gappy, picked at random;
      // every few hundred colors the sender drains the pipe first
      burst = 1'b0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
         gap = burst ? 0 : $urandom_range(0, 19);
         add_color(int'($signed(16'($urandom))), draw_unit(), draw_unit(),
                   gap, (i % 300) == 150);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // done once everything is sent and every predicted pixel has come
      do @(negedge clock);
      while (color_q.size() != 0 || have_staged || start || rgb_expected.size() != 0);
      repeat (END_WAIT) @(negedge clock);

      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // watchdog: ends the run as NOT OK if it never finishes
   initial begin
      #4000000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
